### hw/rtl/pfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_pkg
// Shared types and constants of the pixel format and palette converter.
// ----------------------------------------------------------------------------
package pfpc_pkg;

	// Default palette depth and the fixed field widths.
	localparam int unsigned PALETTE_DEPTH_DEF = 256;
	localparam int unsigned PIX_W  = 32;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned DIST_W = 18;

	// Output format codes.
	typedef enum logic [MODE_W-1:0] {
		FMT_ARGB8888 = 2'd0,
		FMT_RGB565   = 2'd1,
		FMT_ALPHA    = 2'd2,
		FMT_LUT8     = 2'd3
	} fmt_mode_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} pfpc_state_t;

	// Control handed from the sequencer to the match unit.
	typedef struct packed {
		logic clear;
		logic step;
		logic live;
	} pfpc_step_t;

	// Squared ARGB distance between two pixels.
	function automatic logic [DIST_W-1:0] argb_dist(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [7:0]        x;
		logic [7:0]        y;
		logic [7:0]        d;
		logic [DIST_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			x = a[k*8 +: 8];
			y = b[k*8 +: 8];
			d = (x > y) ? (x - y) : (y - x);
			acc = acc + DIST_W'(16'(d) * 16'(d));
		end
		return acc;
	endfunction

	// RGB565 packing of an ARGB word.
	function automatic logic [15:0] pack_565(input logic [PIX_W-1:0] p);
		return {p[23:19], p[15:10], p[7:3]};
	endfunction

endpackage

### hw/rtl/pfpc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_in_if
// Pixel request channel.
// ----------------------------------------------------------------------------
interface pfpc_in_if;
	logic                        valid;
	logic                        ready;
	logic [pfpc_pkg::PIX_W-1:0]  pixel_argb;
	logic                        start_of_image;

	modport source (output valid, output pixel_argb, output start_of_image, input ready);
	modport sink   (input valid, input pixel_argb, input start_of_image, output ready);
endinterface

### hw/rtl/pfpc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_out_if
// Converted result channel.
// ----------------------------------------------------------------------------
interface pfpc_out_if;
	logic                        valid;
	logic                        ready;
	logic [pfpc_pkg::PIX_W-1:0]  out_value;
	logic                        new_entry;
	logic [pfpc_pkg::PIX_W-1:0]  entry_color;

	modport source (output valid, output out_value, output new_entry, output entry_color,
		input ready);
	modport sink   (input valid, input out_value, input new_entry, input entry_color,
		output ready);
endinterface

### hw/rtl/pfpc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_cfg_if
// Format register write channel.
// ----------------------------------------------------------------------------
interface pfpc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pfpc_pkg::MODE_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pfpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_cell
// One palette entry of the rotating palette ring.
// ----------------------------------------------------------------------------
module pfpc_cell (
	input  logic                        clk,
	input  logic                        shift_en,
	input  logic                        load_en,
	input  logic [pfpc_pkg::PIX_W-1:0]  shift_in,
	input  logic [pfpc_pkg::PIX_W-1:0]  load_data,
	output logic [pfpc_pkg::PIX_W-1:0]  color_q
);

	// Take the neighbor's entry while rotating, or a new color when appended.
	always_ff @(posedge clk) begin
		if (load_en) begin
			color_q <= load_data;
		end else if (shift_en) begin
			color_q <= shift_in;
		end
	end

endmodule

### hw/rtl/pfpc_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfpc_match
// Exact match and nearest color tracking at the head of the palette ring.
// ----------------------------------------------------------------------------
module pfpc_match #(
	parameter int unsigned IDX_W = 8
) (
	input  logic                        clk,
	input  pfpc_pkg::pfpc_step_t        ctl,
	input  logic [IDX_W-1:0]            idx,
	input  logic [pfpc_pkg::PIX_W-1:0]  head_color,
	input  logic [pfpc_pkg::PIX_W-1:0]  pixel,
	output logic                        found_q,
	output logic [IDX_W-1:0]            found_idx_q,
	output logic [IDX_W-1:0]            best_idx_q,
	output logic [pfpc_pkg::PIX_W-1:0]  best_color_q
);

	logic [pfpc_pkg::DIST_W-1:0] head_dist;
	logic [pfpc_pkg::DIST_W-1:0] best_dist_q;

	assign head_dist = pfpc_pkg::argb_dist(head_color, pixel);

	// First exact match and first entry of least distance.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			found_q     <= 1'b0;
			best_dist_q <= '1;
		end else if (ctl.step && ctl.live) begin
			if (!found_q && head_color == pixel) begin
				found_q     <= 1'b1;
				found_idx_q <= idx;
			end
			if (head_dist < best_dist_q) begin
				best_dist_q  <= head_dist;
				best_idx_q   <= idx;
				best_color_q <= head_color;
			end
		end
	end

endmodule

### hw/rtl/pixel_format_palette_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_palette_converter_core
// Converts ARGB pixels to ARGB8888, RGB565, alpha or a LUT8 palette index.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in carries one pixel request (pixel_argb, start_of_image); result
//   returns one result request per pixel (out_value, new_entry, entry_color).
//   cfg writes format_mode and is always ready; the user must write it only
//   while idle, unchecked. start_of_image clears the palette before its pixel.
// Timing and throughput:
//   ARGB8888, RGB565 and alpha modes give the result in the cycle after the
//   request; one pixel per cycle while the receiver takes results.
//   LUT8 mode rotates the whole palette ring past one compare unit, so each
//   pixel walks every entry regardless of the fill before the next is taken.
// Reset:
//   arst_n clears the format to ARGB8888, the palette fill and the result
//   valid; palette contents are not cleared and are only read below the fill.
// Stall:
//   A result waits in its output register until taken; a new pixel is taken
//   in the cycle the pending result leaves.
// ----------------------------------------------------------------------------
module pixel_format_palette_converter_core #(
	parameter int unsigned PALETTE_DEPTH = pfpc_pkg::PALETTE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	pfpc_in_if.sink         pixel_in,
	pfpc_out_if.source      result,
	pfpc_cfg_if.sink        cfg
);

	localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);
	localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(PALETTE_DEPTH - 1);

	pfpc_pkg::fmt_mode_t   mode_q;
	pfpc_pkg::pfpc_state_t state_q;
	pfpc_pkg::pfpc_state_t state_d;
	pfpc_pkg::pfpc_step_t  ctl;

	logic [CNT_W-1:0]            used_q;
	logic [CNT_W-1:0]            step_q;
	logic [pfpc_pkg::PIX_W-1:0]  pixel_q;
	logic                        out_valid_q;
	logic [pfpc_pkg::PIX_W-1:0]  out_value_q;
	logic                        new_entry_q;
	logic [pfpc_pkg::PIX_W-1:0]  entry_color_q;

	logic                        accept;
	logic                        out_free;
	logic                        is_lut;
	logic                        room;
	logic                        append;

	logic [pfpc_pkg::PIX_W-1:0]  ring [PALETTE_DEPTH];
	logic                        found;
	logic [IDX_W-1:0]            found_idx;
	logic [IDX_W-1:0]            best_idx;
	logic [pfpc_pkg::PIX_W-1:0]  best_color;

	// Handshakes.
	assign cfg.ready      = 1'b1;
	assign out_free       = !out_valid_q || result.ready;
	assign pixel_in.ready = (state_q == pfpc_pkg::ST_IDLE) && out_free;
	assign accept         = pixel_in.valid && pixel_in.ready;
	assign is_lut         = (mode_q == pfpc_pkg::FMT_LUT8);
	assign room           = (used_q < DEPTH_C);
	assign append         = (state_q == pfpc_pkg::ST_FIN) && !found && room;

	assign result.valid       = out_valid_q;
	assign result.out_value   = out_value_q;
	assign result.new_entry   = new_entry_q;
	assign result.entry_color = entry_color_q;

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pfpc_pkg::FMT_ARGB8888;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= pfpc_pkg::fmt_mode_t'(cfg.data);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfpc_pkg::ST_IDLE: begin
				if (accept && is_lut) begin
					state_d = pfpc_pkg::ST_WALK;
				end
			end
			pfpc_pkg::ST_WALK: begin
				if (step_q == LAST_C) begin
					state_d = pfpc_pkg::ST_FIN;
				end
			end
			pfpc_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = pfpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfpc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		ctl.clear = 1'b0;
		ctl.step  = 1'b0;
		ctl.live  = (step_q < used_q);
		case (state_q)
			pfpc_pkg::ST_IDLE: ctl.clear = accept;
			pfpc_pkg::ST_WALK: ctl.step  = 1'b1;
			default:           ctl.step  = 1'b0;
		endcase
	end

	// Sequencer, fill count and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfpc_pkg::ST_IDLE;
			used_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result is loaded, otherwise a taken result is retired.
			if (accept && !is_lut) begin
				out_valid_q <= 1'b1;
			end else if (state_q == pfpc_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				step_q <= '0;
				if (pixel_in.start_of_image) begin
					used_q <= '0;
				end
			end else if (state_q == pfpc_pkg::ST_WALK) begin
				step_q <= step_q + 1'b1;
			end
			if (append && out_free) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_q       <= pixel_in.pixel_argb;
			new_entry_q   <= 1'b0;
			entry_color_q <= '0;
			case (mode_q)
				pfpc_pkg::FMT_RGB565: out_value_q <= 32'(pfpc_pkg::pack_565(pixel_in.pixel_argb));
				pfpc_pkg::FMT_ALPHA:  out_value_q <= 32'(pixel_in.pixel_argb[31:24]);
				default:              out_value_q <= pixel_in.pixel_argb;
			endcase
		end else if (state_q == pfpc_pkg::ST_FIN && out_free) begin
			if (found) begin
				out_value_q   <= 32'(found_idx);
				new_entry_q   <= 1'b0;
				entry_color_q <= pixel_q;
			end else if (room) begin
				out_value_q   <= 32'(used_q);
				new_entry_q   <= 1'b1;
				entry_color_q <= pixel_q;
			end else begin
				out_value_q   <= 32'(best_idx);
				new_entry_q   <= 1'b0;
				entry_color_q <= best_color;
			end
		end
	end

	// Palette ring: rotates one place per walk step, head at entry zero.
	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		pfpc_cell u_cell (
			.clk       (clk),
			.shift_en  (state_q == pfpc_pkg::ST_WALK),
			.load_en   (append && out_free && (used_q[IDX_W-1:0] == IDX_W'(i))),
			.shift_in  (ring[(i + 1) % PALETTE_DEPTH]),
			.load_data (pixel_q),
			.color_q   (ring[i])
		);
	end

	// Compare unit at the head of the ring.
	pfpc_match #(
		.IDX_W (IDX_W)
	) u_match (
		.clk          (clk),
		.ctl          (ctl),
		.idx          (step_q[IDX_W-1:0]),
		.head_color   (ring[0]),
		.pixel        (pixel_q),
		.found_q      (found),
		.found_idx_q  (found_idx),
		.best_idx_q   (best_idx),
		.best_color_q (best_color)
	);

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_C)
		else $error("palette fill exceeds depth");
	a_new_only_lut: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.new_entry |-> mode_q == pfpc_pkg::FMT_LUT8)
		else $error("new entry outside LUT8 mode");
	a_lut_walks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_lut |=> state_q == pfpc_pkg::ST_WALK && step_q == '0)
		else $error("LUT8 pixel did not start a walk");
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != pfpc_pkg::ST_IDLE |-> !pixel_in.ready)
		else $error("pixel taken during a walk");
`endif

endmodule

### tb/sv/pixel_format_palette_converter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_palette_converter_core_test
// Drives pixel requests in every output format, predicts each result from a
// local palette model and checks every result field in order.
// ----------------------------------------------------------------------------
module pixel_format_palette_converter_core_test;

	localparam int unsigned DEPTH = pfpc_pkg::PALETTE_DEPTH_DEF;
	localparam int unsigned WATCHDOG_CYCLES = 20000;

	typedef struct packed {
		logic [31:0] value;
		logic        added;
		logic [31:0] color;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfpc_in_if  pixel_in ();
	pfpc_out_if result ();
	pfpc_cfg_if cfg ();

	pixel_format_palette_converter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel_in (pixel_in.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	always #4 clk = ~clk;

	// Model state: format, palette and its fill.
	pfpc_pkg::fmt_mode_t cur_fmt = pfpc_pkg::FMT_ARGB8888;
	logic [31:0]  pal_colors [DEPTH];
	int unsigned  pal_fill = 0;
	conv_result_t pending_results [$];
	int unsigned  fail_count = 0;
	int unsigned  idle_cycles = 0;
	logic         stall_enable = 1'b1;

	// Computes the expected result of one pixel and updates the palette.
	function automatic conv_result_t convert_pixel(logic [31:0] p, logic soi);
		conv_result_t r;
		int unsigned best;
		int unsigned best_d;
		int unsigned d;
		int          x;
		bit          found;
		r = '0;
		found = 1'b0;
		if (soi)
			pal_fill = 0;
		case (cur_fmt)
			pfpc_pkg::FMT_ARGB8888: r.value = p;
			pfpc_pkg::FMT_RGB565: r.value = {16'd0, p[23:19], p[15:10], p[7:3]};
			pfpc_pkg::FMT_ALPHA: r.value = {24'd0, p[31:24]};
			default: begin
				for (int i = 0; i < pal_fill && !found; i++) begin
					if (pal_colors[i] == p) begin
						r.value = i;
						found = 1'b1;
					end
				end
				if (!found && pal_fill < DEPTH) begin
					pal_colors[pal_fill] = p;
					r.value = pal_fill;
					r.added = 1'b1;
					pal_fill++;
				end else if (!found) begin
					best = 0;
					best_d = 32'hFFFF_FFFF;
					for (int i = 0; i < DEPTH; i++) begin
						d = 0;
						for (int k = 0; k < 4; k++) begin
							x = int'(pal_colors[i][k*8 +: 8]) - int'(p[k*8 +: 8]);
							d += x * x;
						end
						if (d < best_d) begin
							best_d = d;
							best = i;
						end
					end
					r.value = best;
				end
				r.color = pal_colors[r.value[7:0]];
			end
		endcase
		return r;
	endfunction

	// Drops the pixel valid; called in the cycle of the last accepted request.
	task automatic hold_input();
		pixel_in.valid <= 1'b0;
	endtask

	// Sends one pixel request and records its expected result.
	task automatic send_pixel(logic [31:0] p, logic soi);
		pixel_in.valid <= 1'b1;
		pixel_in.pixel_argb <= p;
		pixel_in.start_of_image <= soi;
		pending_results = {pending_results, convert_pixel(p, soi)};
		do @(posedge clk); while (!pixel_in.ready);
	endtask

	// Sends a pixel, at times after a random gap, so pixels arrive in bursts.
	task automatic send_bursty(logic [31:0] p, logic soi);
		if ($urandom_range(0, 7) == 0) begin
			hold_input();
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		send_pixel(p, soi);
	endtask

	// Waits until every result has arrived, then lets the block settle.
	task automatic drain_results();
		hold_input();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	// Writes the format register while the block is idle.
	task automatic write_format(pfpc_pkg::fmt_mode_t f);
		drain_results();
		cfg.valid <= 1'b1;
		cfg.data <= f;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_fmt = f;
	endtask

	function automatic logic [31:0] rand_pixel();
		return $urandom();
	endfunction

	// Plain formats: field extremes and random pixels.
	task automatic test_plain_formats();
		pfpc_pkg::fmt_mode_t f;
		for (int m = 0; m < 3; m++) begin
			f = pfpc_pkg::fmt_mode_t'(m);
			write_format(f);
			send_pixel(32'h0000_0000, 1'b0);
			send_pixel(32'hFFFF_FFFF, 1'b1);
			send_pixel(32'hA5C3_5A3C, 1'b0);
			for (int i = 0; i < 40; i++)
				send_bursty(rand_pixel(), $urandom_range(0, 9) == 0);
		end
	endtask

	// Palette: reuse of entries, clearing at start of image.
	task automatic test_palette_reuse();
		write_format(pfpc_pkg::FMT_LUT8);
		send_pixel(32'h1122_3344, 1'b1);
		send_pixel(32'h5566_7788, 1'b0);
		send_pixel(32'h1122_3344, 1'b0);
		send_pixel(32'h5566_7788, 1'b1);
		send_pixel(32'h1122_3344, 1'b0);
		for (int i = 0; i < 60; i++)
			send_bursty({8'($urandom_range(0, 3) * 8'h55), 24'h00_00_00}
				| 32'($urandom_range(0, 7)), $urandom_range(0, 19) == 0);
	endtask

	// Palette overflow: fill it, then nearest match.
	task automatic test_palette_full();
		write_format(pfpc_pkg::FMT_LUT8);
		for (int i = 0; i < DEPTH; i++)
			send_bursty({8'hFF, 8'(i), 8'(i), 8'(i)}, i == 0);
		// Pixel off the gray ramp: the nearest entry wins.
		send_pixel({8'hFF, 8'd1, 8'd1, 8'd0}, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		for (int i = 0; i < 40; i++)
			send_bursty(rand_pixel(), 1'b0);
		// Pause until every result has come back.
		hold_input();
		do @(posedge clk); while (pending_results.size() != 0);
		for (int i = 0; i < 20; i++)
			send_bursty(rand_pixel(), 1'b0);
	endtask

	// Mixed random images in random formats, ending back at pass-through.
	task automatic test_random_images();
		for (int img = 0; img < 4; img++) begin
			write_format(pfpc_pkg::fmt_mode_t'($urandom_range(0, 3)));
			stall_enable = (img != 2);
			for (int i = 0; i < 50; i++)
				send_bursty($urandom_range(0, 1) ? rand_pixel()
					: {8'hFF, 16'h0, 8'($urandom_range(0, 15))}, i == 0);
		end
		stall_enable = 1'b1;
		write_format(pfpc_pkg::FMT_ARGB8888);
		send_pixel(rand_pixel(), 1'b0);
	endtask

	// Receiver stalls on a pattern of its own.
	always @(posedge clk) begin
		result.ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		conv_result_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result out_value=%h", result.out_value);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result.out_value !== exp_r.value) begin
					$error("out_value expected %h actual %h", exp_r.value,
						result.out_value);
					fail_count++;
				end
				if (result.new_entry !== exp_r.added) begin
					$error("new_entry expected %b actual %b", exp_r.added,
						result.new_entry);
					fail_count++;
				end
				if (result.entry_color !== exp_r.color) begin
					$error("entry_color expected %h actual %h", exp_r.color,
						result.entry_color);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted request.
	always @(posedge clk) begin
		if ((pixel_in.valid && pixel_in.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		pixel_in.valid = 1'b0;
		pixel_in.pixel_argb = '0;
		pixel_in.start_of_image = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		result.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_formats();
		test_palette_reuse();
		test_palette_full();
		test_random_images();
		drain_results();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### pixel_format_palette_converter_core.f
hw/rtl/pfpc_pkg.sv
hw/rtl/pfpc_in_if.sv
hw/rtl/pfpc_out_if.sv
hw/rtl/pfpc_cfg_if.sv
hw/rtl/pfpc_cell.sv
hw/rtl/pfpc_match.sv
hw/rtl/pixel_format_palette_converter_core.sv
tb/sv/pixel_format_palette_converter_core_test.sv
